// File: rtl/core/dcmu_pkg.sv
`timescale 1ns / 1ps
package dcmu_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 30;

  typedef logic [5:0] slot_t;
  typedef logic [6:0] pc_t;

  // operand / scratch slots
  localparam slot_t SL_X    = 6'd0;
  localparam slot_t SL_Y    = 6'd1;
  localparam slot_t SL_Z    = 6'd2;
  localparam slot_t SL_X2   = 6'd3;
  localparam slot_t SL_Y2   = 6'd4;
  localparam slot_t SL_Z2   = 6'd5;
  localparam slot_t SL_D2   = 6'd6;
  localparam slot_t SL_D4   = 6'd7;
  localparam slot_t SL_ALF  = 6'd8;
  localparam slot_t SL_BET  = 6'd9;
  localparam slot_t SL_RX   = 6'd10;
  localparam slot_t SL_RY   = 6'd11;
  localparam slot_t SL_RZ   = 6'd12;
  localparam slot_t SL_XY   = 6'd13;
  localparam slot_t SL_XZ   = 6'd14;
  localparam slot_t SL_YZ   = 6'd15;
  localparam slot_t SL_BXY  = 6'd16;
  localparam slot_t SL_BXZ  = 6'd17;
  localparam slot_t SL_BYZ  = 6'd18;
  localparam slot_t SL_SZY  = 6'd19;
  localparam slot_t SL_SZX  = 6'd20;
  localparam slot_t SL_SYX  = 6'd21;
  localparam slot_t SL_S0   = 6'd22;
  localparam slot_t SL_C0   = 6'd31;
  localparam slot_t SL_NM0  = 6'd40;
  localparam int    MEM_DEPTH = 49;
  localparam slot_t SL_K6   = 6'd49;
  localparam slot_t SL_K24  = 6'd50;
  localparam slot_t SL_K120 = 6'd51;
  localparam slot_t SL_K720 = 6'd52;
  localparam slot_t SL_KH   = 6'd53;
  localparam slot_t SL_ONE  = 6'd54;
  localparam slot_t SL_ZERO = 6'd55;

  typedef enum logic [1:0] {M_ADD, M_SUB, M_NEG} mode_t;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_MUL, S_ACC} state_t;

  typedef struct packed {
    slot_t a;
    slot_t b;
    logic  byp;
    mode_t mode;
    logic  first;
    logic  last;
    slot_t dst;
    logic  pub;
  } uop_t;

  localparam pc_t INIT_LEN = 7'd9;
  localparam pc_t NM_BASE  = 7'd54;
  localparam pc_t CP_BASE  = 7'd90;
  localparam pc_t PROG_LEN = 7'd99;

  function automatic uop_t mk(input slot_t a, input slot_t b, input logic byp,
                              input mode_t mode, input logic first, input logic last,
                              input slot_t dst);
    uop_t u;
    u = '{a: a, b: b, byp: byp, mode: mode, first: first, last: last, dst: dst,
          pub: 1'b0};
    return u;
  endfunction

  // microcode: init program, then one update
  function automatic uop_t prog(input pc_t pc);
    uop_t u;
    pc_t j;
    logic [4:0] e;
    logic [1:0] r;
    logic [4:0] c;
    slot_t rb;
    u = mk(SL_ZERO, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b1, SL_NM0);
    if (pc < INIT_LEN) begin
      u = mk((pc == 7'd0 || pc == 7'd4 || pc == 7'd8) ? SL_ONE : SL_ZERO, SL_ZERO,
             1'b1, M_ADD, 1'b1, 1'b1, SL_C0 + slot_t'(pc));
    end else if (pc >= NM_BASE && pc < CP_BASE) begin
      j = pc - NM_BASE;
      e = j[6:2];
      r = (e >= 5'd6) ? 2'd2 : (e >= 5'd3) ? 2'd1 : 2'd0;
      c = e - 5'(3 * r);
      rb = SL_C0 + slot_t'(3 * r);
      case (j[1:0])
        2'd0: u = mk(rb, SL_S0 + slot_t'(c), 1'b0, M_ADD, 1'b1, 1'b0, SL_NM0);
        2'd1: u = mk(rb + 6'd1, SL_S0 + 6'd3 + slot_t'(c), 1'b0, M_ADD, 1'b0, 1'b0,
                     SL_NM0);
        2'd2: u = mk(rb + 6'd2, SL_S0 + 6'd6 + slot_t'(c), 1'b0, M_ADD, 1'b0, 1'b0,
                     SL_NM0);
        default: u = mk(rb + slot_t'(c), SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1,
                        SL_NM0 + slot_t'(e));
      endcase
    end else if (pc >= CP_BASE && pc < PROG_LEN) begin
      j = pc - CP_BASE;
      u = mk(SL_NM0 + slot_t'(j), SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b1, SL_C0 + slot_t'(j));
      u.pub = 1'b1;
    end else begin
      case (pc)
        7'd9:  u = mk(SL_X, SL_X, 1'b0, M_ADD, 1'b1, 1'b1, SL_X2);
        7'd10: u = mk(SL_Y, SL_Y, 1'b0, M_ADD, 1'b1, 1'b1, SL_Y2);
        7'd11: u = mk(SL_Z, SL_Z, 1'b0, M_ADD, 1'b1, 1'b1, SL_Z2);
        7'd12: u = mk(SL_X2, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_D2);
        7'd13: u = mk(SL_Y2, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b0, SL_D2);
        7'd14: u = mk(SL_Z2, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_D2);
        7'd15: u = mk(SL_D2, SL_D2, 1'b0, M_ADD, 1'b1, 1'b1, SL_D4);
        7'd16: u = mk(SL_D2, SL_K6, 1'b0, M_NEG, 1'b1, 1'b0, SL_ALF);
        7'd17: u = mk(SL_D4, SL_K120, 1'b0, M_ADD, 1'b0, 1'b1, SL_ALF);
        7'd18: u = mk(SL_KH, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_BET);
        7'd19: u = mk(SL_D2, SL_K24, 1'b0, M_SUB, 1'b0, 1'b0, SL_BET);
        7'd20: u = mk(SL_D4, SL_K720, 1'b0, M_ADD, 1'b0, 1'b1, SL_BET);
        7'd21: u = mk(SL_ALF, SL_X, 1'b0, M_ADD, 1'b1, 1'b0, SL_RX);
        7'd22: u = mk(SL_X, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_RX);
        7'd23: u = mk(SL_ALF, SL_Y, 1'b0, M_ADD, 1'b1, 1'b0, SL_RY);
        7'd24: u = mk(SL_Y, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_RY);
        7'd25: u = mk(SL_ALF, SL_Z, 1'b0, M_ADD, 1'b1, 1'b0, SL_RZ);
        7'd26: u = mk(SL_Z, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_RZ);
        7'd27: u = mk(SL_X, SL_Y, 1'b0, M_ADD, 1'b1, 1'b1, SL_XY);
        7'd28: u = mk(SL_X, SL_Z, 1'b0, M_ADD, 1'b1, 1'b1, SL_XZ);
        7'd29: u = mk(SL_Y, SL_Z, 1'b0, M_ADD, 1'b1, 1'b1, SL_YZ);
        7'd30: u = mk(SL_XY, SL_BET, 1'b0, M_ADD, 1'b1, 1'b1, SL_BXY);
        7'd31: u = mk(SL_XZ, SL_BET, 1'b0, M_ADD, 1'b1, 1'b1, SL_BXZ);
        7'd32: u = mk(SL_YZ, SL_BET, 1'b0, M_ADD, 1'b1, 1'b1, SL_BYZ);
        7'd33: u = mk(SL_Z2, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_SZY);
        7'd34: u = mk(SL_Y2, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_SZY);
        7'd35: u = mk(SL_Z2, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_SZX);
        7'd36: u = mk(SL_X2, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_SZX);
        7'd37: u = mk(SL_Y2, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_SYX);
        7'd38: u = mk(SL_X2, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_SYX);
        7'd39: u = mk(SL_BET, SL_SZY, 1'b0, M_NEG, 1'b1, 1'b1, SL_S0);
        7'd40: u = mk(SL_BET, SL_SZX, 1'b0, M_NEG, 1'b1, 1'b1, SL_S0 + 6'd4);
        7'd41: u = mk(SL_BET, SL_SYX, 1'b0, M_NEG, 1'b1, 1'b1, SL_S0 + 6'd8);
        7'd42: u = mk(SL_RZ, SL_ZERO, 1'b1, M_NEG, 1'b1, 1'b0, SL_S0 + 6'd1);
        7'd43: u = mk(SL_BXY, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd1);
        7'd44: u = mk(SL_RY, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_S0 + 6'd2);
        7'd45: u = mk(SL_BXZ, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd2);
        7'd46: u = mk(SL_RZ, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_S0 + 6'd3);
        7'd47: u = mk(SL_BXY, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd3);
        7'd48: u = mk(SL_RX, SL_ZERO, 1'b1, M_NEG, 1'b1, 1'b0, SL_S0 + 6'd5);
        7'd49: u = mk(SL_BYZ, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd5);
        7'd50: u = mk(SL_RY, SL_ZERO, 1'b1, M_NEG, 1'b1, 1'b0, SL_S0 + 6'd6);
        7'd51: u = mk(SL_BXZ, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd6);
        7'd52: u = mk(SL_RX, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b0, SL_S0 + 6'd7);
        7'd53: u = mk(SL_BYZ, SL_ZERO, 1'b1, M_ADD, 1'b0, 1'b1, SL_S0 + 6'd7);
        default: u = mk(SL_ZERO, SL_ZERO, 1'b1, M_ADD, 1'b1, 1'b1, SL_NM0);
      endcase
    end
    return u;
  endfunction

endpackage

// File: rtl/core/direction_cosine_matrix_update_core.sv
`timescale 1ns / 1ps
// Strapdown direction cosine matrix update.
// Input channel (in_valid/in_ready): one transaction carries the three
// incremental gyro angles rot_x, rot_y, rot_z (signed Q format).
// Output channel (out_valid/out_ready): one transaction per input carries
// the nine updated matrix elements c11..c33, row by row.
// Internally a small microcode sequencer drives one shared multiplier and
// one accumulator; scratch values live in a 1-write/2-read register array.
// Each micro-op passes through operand read, multiply and round/accumulate,
// and one update runs 90 micro-ops. in_ready is high only while the
// sequencer is idle, so a new input transaction is taken only after the
// previous update has run to its end.
// Reset: the sequencer first runs a 9-step init pass that loads the
// identity matrix; in_ready stays low until it ends.
// Receiver stall: the result sits in its output registers; the next input
// is still taken and computed, and only the final copy-back of the new
// matrix waits until the pending result has been taken.
module direction_cosine_matrix_update_core
  import dcmu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] rot_x,
  input  logic signed [WORD_BITS-1:0] rot_y,
  input  logic signed [WORD_BITS-1:0] rot_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] c11,
  output logic signed [WORD_BITS-1:0] c12,
  output logic signed [WORD_BITS-1:0] c13,
  output logic signed [WORD_BITS-1:0] c21,
  output logic signed [WORD_BITS-1:0] c22,
  output logic signed [WORD_BITS-1:0] c23,
  output logic signed [WORD_BITS-1:0] c31,
  output logic signed [WORD_BITS-1:0] c32,
  output logic signed [WORD_BITS-1:0] c33
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int AW = WORD_BITS + 3;

  // constants: rounded to nearest, clipped to the word
  localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
  localparam longint WMAX_L = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam longint ONE_C  = (ONE_L > WMAX_L) ? WMAX_L : ONE_L;
  localparam longint K6_L   = ((ONE_L + 3) / 6 > WMAX_L) ? WMAX_L : (ONE_L + 3) / 6;
  localparam longint K24_L  = ((ONE_L + 12) / 24 > WMAX_L) ? WMAX_L : (ONE_L + 12) / 24;
  localparam longint K120_L = ((ONE_L + 60) / 120 > WMAX_L) ? WMAX_L : (ONE_L + 60) / 120;
  localparam longint K720_L = ((ONE_L + 360) / 720 > WMAX_L) ? WMAX_L : (ONE_L + 360) / 720;
  localparam longint KH_L   = (ONE_L / 2 > WMAX_L) ? WMAX_L : ONE_L / 2;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  state_t state, state_next;
  pc_t    pc;
  uop_t   u;

  logic signed [W-1:0] mem [0:MEM_DEPTH-1];
  logic signed [W-1:0] ra, rb;
  logic signed [W-1:0] xr, yr, zr;
  logic signed [W-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  bypv;
  logic signed [AW-1:0] acc;
  logic signed [W-1:0]  cq [0:8];

  logic [PW-1:0]   pmag;
  logic [PW:0]     prnd;
  logic [PW:0]     psh;
  logic signed [W-1:0]  pterm;
  logic signed [W-1:0]  tval;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] acc_sum;
  logic signed [W-1:0]  res;
  logic [3:0]           cidx;

  logic in_fire, stall_pub, prog_end;

  assign u = prog(pc);

  function automatic logic signed [W-1:0] src(input slot_t s, input logic signed [W-1:0] m);
    logic signed [W-1:0] v;
    case (s)
      SL_X:    v = xr;
      SL_Y:    v = yr;
      SL_Z:    v = zr;
      SL_K6:   v = K6_L[W-1:0];
      SL_K24:  v = K24_L[W-1:0];
      SL_K120: v = K120_L[W-1:0];
      SL_K720: v = K720_L[W-1:0];
      SL_KH:   v = KH_L[W-1:0];
      SL_ONE:  v = ONE_C[W-1:0];
      SL_ZERO: v = '0;
      default: v = m;
    endcase
    return v;
  endfunction

  assign opa = src(u.a, ra);
  assign opb = src(u.b, rb);

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign stall_pub = u.pub && out_valid;
  assign prog_end  = (pc == PROG_LEN - 7'd1) || (pc == INIT_LEN - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = S_RD;
      S_RD: begin
        if (!stall_pub) state_next = S_MUL;
      end
      S_MUL: state_next = S_ACC;
      S_ACC: state_next = prog_end ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // rounding of the product (magnitude, half-up, shift, clip), then sign and saturating accumulate
  always_comb begin
    pmag = prod[PW-1] ? PW'(-prod) : PW'(prod);
    prnd = {1'b0, pmag} + ((PW+1)'(1) << (FRAC_BITS - 1));
    psh  = prnd >> FRAC_BITS;
    if (prod[PW-1]) begin
      pterm = (psh >= ((PW+1)'(1) << (W - 1))) ? WMIN : -psh[W-1:0];
    end else begin
      pterm = (psh > (PW+1)'(WMAX)) ? WMAX : psh[W-1:0];
    end
    tval = u.byp ? bypv : pterm;
    case (u.mode)
      M_SUB:   term = -AW'(tval);
      M_NEG:   term = (tval == WMIN) ? AW'(WMAX) : -AW'(tval);
      default: term = AW'(tval);
    endcase
    acc_sum = (u.first ? AW'(0) : acc) + term;
    if (acc_sum > AW'(WMAX)) begin
      res = WMAX;
    end else if (acc_sum < AW'(WMIN)) begin
      res = WMIN;
    end else begin
      res = acc_sum[W-1:0];
    end
    cidx = 4'(u.dst - SL_C0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (in_fire) begin
      pc <= INIT_LEN;
    end else if (state == S_ACC && !prog_end) begin
      pc <= pc + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xr <= rot_x;
      yr <= rot_y;
      zr <= rot_z;
    end
    if (state == S_RD) begin
      ra <= (u.a < slot_t'(MEM_DEPTH)) ? mem[u.a] : '0;
      rb <= (u.b < slot_t'(MEM_DEPTH)) ? mem[u.b] : '0;
    end
    if (state == S_MUL) begin
      prod <= PW'(opa) * PW'(opb);
      bypv <= opa;
    end
    if (state == S_ACC) begin
      acc <= acc_sum;
      if (u.last) mem[u.dst] <= res;
      if (u.last && u.pub) cq[cidx] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ACC && pc == PROG_LEN - 7'd1) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign c11 = cq[0];
  assign c12 = cq[1];
  assign c13 = cq[2];
  assign c21 = cq[3];
  assign c22 = cq[4];
  assign c23 = cq[5];
  assign c31 = cq[6];
  assign c32 = cq[7];
  assign c33 = cq[8];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top
  import dcmu_pkg::*;
();

  localparam int W = WORD_BITS_DEF;
  localparam int F = FRAC_BITS_DEF;
  localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint WMIN = -(64'sd1 <<< (W - 1));
  localparam longint ONE = 64'sd1 <<< F;

  typedef struct {
    longint c[9];
  } attitude_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] rot_x = '0, rot_y = '0, rot_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] c11, c12, c13, c21, c22, c23, c31, c32, c33;

  direction_cosine_matrix_update_core DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  longint    dcm[9];
  attitude_t pending_dcm[$];
  int        errors = 0;
  int        sent = 0;
  int        checked = 0;
  bit        idle_on = 1'b1;
  int        hold_req = 0;

  function automatic longint sat(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint negs(longint v);
    return sat(-v);
  endfunction

  // exact product, round half away from zero, saturate
  function automatic longint qmul(longint a, longint b);
    longint p, m, r, lim;
    bit neg_p;
    p = a * b;
    neg_p = p < 0;
    m = neg_p ? -p : p;
    r = (m + (64'sd1 <<< (F - 1))) >>> F;
    lim = neg_p ? -WMIN : WMAX;
    if (r > lim) r = lim;
    return neg_p ? -r : r;
  endfunction

  function automatic attitude_t rotate_dcm(longint x, longint y, longint z);
    longint k6, k24, k120, k720, kh;
    longint x2, y2, z2, d2, d4, alf, bet, rx, ry, rz, bxy, bxz, byz;
    longint s[9], nm[9];
    attitude_t res;
    k6 = sat((ONE + 3) / 6);
    k24 = sat((ONE + 12) / 24);
    k120 = sat((ONE + 60) / 120);
    k720 = sat((ONE + 360) / 720);
    kh = sat(ONE / 2);
    x2 = qmul(x, x); y2 = qmul(y, y); z2 = qmul(z, z);
    d2 = sat(x2 + y2 + z2);
    d4 = qmul(d2, d2);
    alf = sat(negs(qmul(d2, k6)) + qmul(d4, k120));
    bet = sat(kh - qmul(d2, k24) + qmul(d4, k720));
    rx = sat(qmul(alf, x) + x);
    ry = sat(qmul(alf, y) + y);
    rz = sat(qmul(alf, z) + z);
    bxy = qmul(qmul(x, y), bet);
    bxz = qmul(qmul(x, z), bet);
    byz = qmul(qmul(y, z), bet);
    s[0] = negs(qmul(bet, sat(z2 + y2)));
    s[4] = negs(qmul(bet, sat(z2 + x2)));
    s[8] = negs(qmul(bet, sat(y2 + x2)));
    s[1] = sat(negs(rz) + bxy);
    s[2] = sat(ry + bxz);
    s[3] = sat(rz + bxy);
    s[5] = sat(negs(rx) + byz);
    s[6] = sat(negs(ry) + bxz);
    s[7] = sat(rx + byz);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        nm[r*3+c] = sat(qmul(dcm[r*3], s[c]) + qmul(dcm[r*3+1], s[3+c]) +
                        qmul(dcm[r*3+2], s[6+c]) + dcm[r*3+c]);
    for (int i = 0; i < 9; i++) begin
      dcm[i] = nm[i];
      res.c[i] = nm[i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
  endtask

  // one input transaction; valid stays up across back-to-back items
  task automatic send_rotation(logic signed [W-1:0] x, y, z);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rot_x <= x; rot_y <= y; rot_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_dcm.push_back(rotate_dcm(longint'(x), longint'(y), longint'(z)));
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_dcm.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_word();
    return W'($urandom());
  endfunction

  // small angles, like real gyro increments (up to about 2^(1-b) rad for a shift b of 8 to 30)
  function automatic logic signed [W-1:0] rand_angle();
    int b;
    b = $urandom_range(8, 30);
    return W'($signed($urandom()) >>> b);
  endfunction

  task automatic test_directed();
    send_rotation('0, '0, '0);
    send_rotation(W'(WMAX), W'(WMAX), W'(WMAX));
    send_rotation(W'(WMIN), W'(WMIN), W'(WMIN));
    send_rotation(W'(WMIN), '0, '0);
    send_rotation('0, W'(WMAX), '0);
    send_rotation('0, '0, W'(WMIN));
    drain();
    // small single-axis turns of both signs, then mixed, tiny, extreme and walking-bit rotations
    send_rotation(W'(ONE / 100), '0, '0);
    send_rotation('0, -W'(ONE / 100), '0);
    send_rotation('0, '0, W'(ONE / 100));
    send_rotation(W'(ONE), W'(-ONE), W'(ONE / 2));
    send_rotation(W'(1), W'(-1), W'(1));
    send_rotation(W'(WMAX), W'(WMIN), '0);
    for (int b = 0; b < W; b += 4)
      send_rotation(W'(64'sd1 <<< b), W'(64'sd1 <<< ((b + 1) % W)),
                    W'(64'sd1 <<< ((b + 2) % W)));
  endtask

  task automatic test_random_small(int n);
    repeat (n) send_rotation(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_random_full(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_rotation(rand_word(), rand_word(), rand_word());
      else
        send_rotation(rand_angle(), rand_word(), rand_angle());
    end
  endtask

  // receiver holds off while inputs keep coming so the core backs up
  task automatic test_backpressure();
    hold_req = 2000;
    test_random_small(4);
    drain();
  endtask

  task automatic test_no_idle(int n);
    idle_on = 1'b0;
    test_random_small(n);
    idle_on = 1'b1;
  endtask

  // receiver: random gap after each transaction, or a long hold on request
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n = idle_on ? $urandom_range(0, 13) : 0;
        if (hold_req > 0) begin
          n = hold_req;
          hold_req = 0;
        end
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    attitude_t want;
    logic signed [W-1:0] got[9];
    if (!rst && out_valid && out_ready) begin
      got = '{c11, c12, c13, c21, c22, c23, c31, c32, c33};
      if (pending_dcm.size() == 0) begin
        errors++;
        $display("unexpected result transaction");
      end else begin
        want = pending_dcm.pop_front();
        for (int i = 0; i < 9; i++)
          if (longint'(got[i]) != want.c[i])
            report_mismatch($sformatf("c%0d%0d", i / 3 + 1, i % 3 + 1),
                            longint'(got[i]), want.c[i]);
      end
      checked++;
    end
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", pending_dcm.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < 9; i++) dcm[i] = (i % 4 == 0) ? sat(ONE) : 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_small(250);
    drain();
    test_no_idle(40);
    test_random_full(230);
    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d updates: directed extremes, small and full-range angles,", sent);
    $display("long receiver hold, drained pauses and back-to-back traffic; %0d checked",
             checked);
    if (errors == 0 && pending_dcm.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
